### hw/rtl/http_request_stream_parser_top_macros.svh
// assertion macros for the request parser checker
`ifndef HTTP_REQUEST_STREAM_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define HRSP_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("hrsp assertion failed");

// next-cycle implication
`define HRSP_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("hrsp assertion failed");

`endif

### hw/rtl/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// types, codes and match strings shared by the request parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrsp_pkg;

  localparam int LEN_W = 32;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       field_tag;
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             field_end;
    logic [2:0]       status;
    logic             keep_alive;
    logic             parsing;
    logic [LEN_W-1:0] content_length;
  } out_word_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b0000000001,
    PH_METHOD   = 10'b0000000010,
    PH_PATH     = 10'b0000000100,
    PH_QNAME    = 10'b0000001000,
    PH_QVALUE   = 10'b0000010000,
    PH_VERSION  = 10'b0000100000,
    PH_HNAME    = 10'b0001000000,
    PH_HVALUE   = 10'b0010000000,
    PH_BLANK_LF = 10'b0100000000,
    PH_BODY     = 10'b1000000000
  } phase_t;

  localparam logic [2:0] ST_INCOMPLETE  = 3'd0;
  localparam logic [2:0] ST_COMPLETE    = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_REQUEST = 3'd4;
  localparam logic [2:0] ST_BAD_ESCAPE  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW    = 3'd6;

  localparam logic [3:0] TAG_NONE    = 4'd0;
  localparam logic [3:0] TAG_METHOD  = 4'd1;
  localparam logic [3:0] TAG_PATH    = 4'd2;
  localparam logic [3:0] TAG_QNAME   = 4'd3;
  localparam logic [3:0] TAG_QVALUE  = 4'd4;
  localparam logic [3:0] TAG_VERSION = 4'd5;
  localparam logic [3:0] TAG_HNAME   = 4'd6;
  localparam logic [3:0] TAG_HVALUE  = 4'd7;
  localparam logic [3:0] TAG_BODY    = 4'd8;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       mpos;
    logic [7:0]       mcand;
    logic [2:0]       vcand;
    logic [1:0]       hncand;
    logic [1:0]       hvcand;
    logic [1:0]       esc;
    logic [3:0]       hi;
    logic [LEN_W-1:0] dlen;
    logic [1:0]       nph;
    logic [LEN_W:0]   bcnt;
    logic             ka;
    logic [2:0]       status;
    logic             started;
  } st_t;

  localparam st_t RESET_ST = '{
    phase: PH_IDLE, mpos: 4'd0, mcand: 8'hff, vcand: 3'h7, hncand: 2'h3,
    hvcand: 2'h3, esc: 2'd0, hi: 4'd0, dlen: '0, nph: 2'd0, bcnt: '0,
    ka: 1'b0, status: ST_INCOMPLETE, started: 1'b0};

  // strings right-aligned in 16 bytes
  localparam logic [127:0] METH_TXT [8] = '{
    128'("GET"), 128'("POST"), 128'("OPTIONS"), 128'("HEAD"),
    128'("PUT"), 128'("DELETE"), 128'("TRACE"), 128'("CONNECT")};
  localparam logic [3:0] METH_LEN [8] = '{4'd3, 4'd4, 4'd7, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7};
  localparam logic [127:0] VER_TXT [3] = '{
    128'("HTTP/1.0"), 128'("HTTP/1.1"), 128'("HTTP/2.0")};
  localparam logic [3:0] VER_LEN [3] = '{4'd8, 4'd8, 4'd8};
  localparam logic [127:0] HN_TXT [2] = '{128'("Content-Length"), 128'("Connection")};
  localparam logic [3:0] HN_LEN [2] = '{4'd14, 4'd10};
  localparam logic [127:0] HV_TXT [2] = '{128'("keep-alive"), 128'("close")};
  localparam logic [3:0] HV_LEN [2] = '{4'd10, 4'd5};

  // true when byte b sits at position pos of a string of length len
  function automatic logic txt_hit(logic [127:0] s, logic [3:0] len, logic [3:0] pos,
                                   logic [7:0] b);
    logic [3:0] k;
    k = len - 4'd1 - pos;
    return (pos < len) && (s[{k, 3'b000} +: 8] == b);
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= "0" && c <= "9") r = {1'b0, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b0, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b0, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

endpackage

### hw/rtl/http_request_stream_parser_top.sv
// ----------------------------------------------------------------------------
// http_request_stream_parser_top
// byte-serial request parser with field tagging and status
// ----------------------------------------------------------------------------
// One request byte or clear command is taken per cycle and its result word
// appears on the output register in the next cycle; throughput is one word
// per cycle, set by the state register fed by the combinational hrsp_step.
// A new word is taken whenever the output register is empty or being read.
`timescale 1ns / 1ps

module http_request_stream_parser_top import hrsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  st_t       st_r;
  st_t       st_nxt;
  out_word_t res;
  out_word_t out_r;
  logic      out_valid_r;
  logic      in_acc;

  hrsp_step u_step (
    .st      (st_r),
    .in_word (in_data),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= RESET_ST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/hrsp_step.sv
// ----------------------------------------------------------------------------
// hrsp_step
// next-state and result logic for one request byte or clear command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrsp_step import hrsp_pkg::*; (
  input  st_t       st,
  input  in_word_t  in_word,
  output st_t       st_nxt,
  output out_word_t res
);

  function automatic st_t do_fail(st_t s, logic [2:0] code);
    st_t r;
    r = s;
    if (s.status == ST_INCOMPLETE || s.status == ST_COMPLETE) r.status = code;
    return r;
  endfunction

  function automatic st_t do_close(st_t s, phase_t nx);
    st_t r;
    r = s;
    if (s.esc != 2'd0) r = do_fail(r, ST_BAD_ESCAPE);
    r.esc     = 2'd0;
    r.hi      = 4'd0;
    r.mpos    = 4'd0;
    r.started = 1'b0;
    r.phase   = nx;
    return r;
  endfunction

  st_t          n;
  logic [3:0]   tag;
  logic [7:0]   ob;
  logic         v;
  logic         fe;
  logic [7:0]   b;
  logic [7:0]   mm;
  logic [2:0]   vm;
  logic [1:0]   hm;
  logic [4:0]   h;
  logic         digit;
  logic [LEN_W+3:0] acc;
  logic         do_acc;
  logic [LEN_W:0] bc_inc;

  assign b = in_word.data_byte;

  always_comb begin
    n      = st;
    tag    = TAG_NONE;
    ob     = 8'd0;
    v      = 1'b0;
    fe     = 1'b0;
    mm     = 8'd0;
    vm     = 3'd0;
    hm     = 2'd0;
    h      = hex_val(b);
    digit  = (b >= "0") && (b <= "9");
    acc    = (LEN_W+4)'({st.dlen, 3'b000}) + (LEN_W+4)'({st.dlen, 1'b0}) +
             (LEN_W+4)'(b - "0");
    do_acc = 1'b0;
    bc_inc = st.bcnt + 1'b1;
    if (in_word.kind) begin
      n = RESET_ST;
    end else if (st.status == ST_INCOMPLETE || st.status == ST_COMPLETE) begin
      if (n.phase == PH_IDLE) n.phase = PH_METHOD;
      unique case (n.phase)
        PH_METHOD: begin
          tag = TAG_METHOD;
          if (b == " ") begin
            fe = 1'b1;
            for (int i = 0; i < 8; i++) mm[i] = n.mcand[i] && (METH_LEN[i] == n.mpos);
            if (mm[1:0] == 2'b00) n = do_fail(n, (mm != 8'd0) ? ST_BAD_METHOD : ST_BAD_REQUEST);
            n = do_close(n, PH_PATH);
          end else begin
            for (int i = 0; i < 8; i++)
              if (!txt_hit(METH_TXT[i], METH_LEN[i], n.mpos, b)) n.mcand[i] = 1'b0;
            if (n.mpos != 4'd15) n.mpos = n.mpos + 4'd1;
            n.started = 1'b1;
            v  = 1'b1;
            ob = b;
          end
        end
        PH_PATH, PH_QNAME, PH_QVALUE: begin
          tag = (n.phase == PH_PATH) ? TAG_PATH : (n.phase == PH_QNAME) ? TAG_QNAME : TAG_QVALUE;
          if (b == " ") begin
            fe = 1'b1;
            n  = do_close(n, PH_VERSION);
          end else if (n.phase == PH_PATH && b == "?") begin
            fe = 1'b1;
            n  = do_close(n, PH_QNAME);
          end else if (n.phase == PH_QNAME && b == "=") begin
            fe = 1'b1;
            n  = do_close(n, PH_QVALUE);
          end else if (n.phase == PH_QVALUE && b == "&") begin
            fe = 1'b1;
            n  = do_close(n, PH_QNAME);
          end else begin
            n.started = 1'b1;
            if (n.esc == 2'd0) begin
              if (b == "%") n.esc = 2'd1;
              else begin
                v  = 1'b1;
                ob = (b == "+") ? 8'h20 : b;
              end
            end else if (h[4]) begin
              n     = do_fail(n, ST_BAD_ESCAPE);
              n.esc = 2'd0;
            end else if (n.esc == 2'd1) begin
              n.hi  = h[3:0];
              n.esc = 2'd2;
            end else begin
              ob    = {n.hi, h[3:0]};
              n.esc = 2'd0;
              v     = 1'b1;
            end
          end
        end
        PH_VERSION: begin
          tag = TAG_VERSION;
          if (b == 8'h0a) begin
            fe = 1'b1;
            for (int i = 0; i < 3; i++) vm[i] = n.vcand[i] && (VER_LEN[i] == n.mpos);
            if (vm[1:0] == 2'b00) n = do_fail(n, vm[2] ? ST_BAD_VERSION : ST_BAD_REQUEST);
            n = do_close(n, PH_HNAME);
            n.hncand = 2'h3;
          end else if (b != 8'h0d) begin
            for (int i = 0; i < 3; i++)
              if (!txt_hit(VER_TXT[i], VER_LEN[i], n.mpos, b)) n.vcand[i] = 1'b0;
            if (n.mpos != 4'd15) n.mpos = n.mpos + 4'd1;
            n.started = 1'b1;
            v  = 1'b1;
            ob = b;
          end
        end
        PH_HNAME: begin
          if (!n.started && b == 8'h0d) begin
            n.phase = PH_BLANK_LF;
          end else begin
            tag = TAG_HNAME;
            n.started = 1'b1;
            if (b == " ") begin
              fe = 1'b1;
              for (int i = 0; i < 2; i++)
                if (HN_LEN[i] != n.mpos) n.hncand[i] = 1'b0;
              n.hvcand = 2'h3;
              if (n.hncand[0]) begin
                n.dlen = '0;
                n.nph  = 2'd0;
              end
              n = do_close(n, PH_HVALUE);
            end else if (b != ":") begin
              for (int i = 0; i < 2; i++)
                if (!txt_hit(HN_TXT[i], HN_LEN[i], n.mpos, b)) n.hncand[i] = 1'b0;
              if (n.mpos != 4'd15) n.mpos = n.mpos + 4'd1;
              v  = 1'b1;
              ob = b;
            end
          end
        end
        PH_HVALUE: begin
          tag = TAG_HVALUE;
          if (b == 8'h0a) begin
            fe = 1'b1;
            if (n.hncand[0]) begin
              if (n.nph == 2'd0 || n.nph == 2'd3) n = do_fail(n, ST_BAD_REQUEST);
            end else if (n.hncand[1]) begin
              for (int i = 0; i < 2; i++) hm[i] = n.hvcand[i] && (HV_LEN[i] == n.mpos);
              if (hm[0]) n.ka = 1'b1;
              else if (hm[1]) n.ka = 1'b0;
              else n = do_fail(n, ST_BAD_REQUEST);
            end
            n = do_close(n, PH_HNAME);
            n.hncand = 2'h3;
          end else if (b != 8'h0d) begin
            for (int i = 0; i < 2; i++)
              if (!txt_hit(HV_TXT[i], HV_LEN[i], n.mpos, b)) n.hvcand[i] = 1'b0;
            if (n.mpos != 4'd15) n.mpos = n.mpos + 4'd1;
            if (n.hncand[0]) begin
              if (n.nph == 2'd0) begin
                if (b == " " || b == 8'h09) n.nph = 2'd0;
                else if (!digit) n.nph = 2'd3;
                else begin
                  n.nph  = 2'd1;
                  do_acc = 1'b1;
                end
              end else if (n.nph == 2'd1) begin
                if (!digit) n.nph = 2'd2;
                else do_acc = 1'b1;
              end
              if (do_acc) n.dlen = (acc[LEN_W+3:LEN_W] != 4'd0) ? '1 : acc[LEN_W-1:0];
            end
            n.started = 1'b1;
            v  = 1'b1;
            ob = b;
          end
        end
        PH_BLANK_LF: begin
          if (b == 8'h0a) begin
            n.phase = PH_BODY;
            if (n.dlen == '0) n.status = ST_COMPLETE;
          end else begin
            n = do_fail(n, ST_BAD_REQUEST);
          end
        end
        PH_BODY: begin
          tag = TAG_BODY;
          if (n.dlen == '0) begin
            n = do_fail(n, ST_BAD_REQUEST);
          end else if (n.bcnt < {1'b0, n.dlen}) begin
            n.bcnt = bc_inc;
            v  = 1'b1;
            ob = b;
            if (bc_inc == {1'b0, n.dlen}) n.status = ST_COMPLETE;
          end else begin
            n.bcnt = {1'b0, n.dlen} + 1'b1;
            n = do_fail(n, ST_OVERFLOW);
          end
        end
        default: begin
          n = do_fail(n, ST_BAD_REQUEST);
        end
      endcase
    end
    st_nxt = n;
    res.field_tag      = tag;
    res.out_byte       = ob;
    res.out_valid      = v;
    res.field_end      = fe;
    res.status         = n.status;
    res.keep_alive     = n.ka;
    res.parsing        = (n.phase != PH_IDLE) && (n.status != ST_COMPLETE);
    res.content_length = n.dlen;
  end

endmodule

### hw/rtl/hrsp_checker.sv
// ----------------------------------------------------------------------------
// hrsp_checker
// port-level checks for the request parser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_stream_parser_top_macros.svh"

module hrsp_checker import hrsp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // an accepted word always shows a result next cycle
  `HRSP_ASSERT_NXT(a_acc_result, in_valid && in_ready, out_valid)
  // a held result keeps its value
  `HRSP_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // no data byte without the data flag
  `HRSP_ASSERT_IMP(a_byte_zero, out_valid && !out_data.out_valid, out_data.out_byte == 8'd0)
  // a clear leaves an idle, incomplete parser
  `HRSP_ASSERT_NXT(a_clear, in_valid && in_ready && in_data.kind,
                   out_data.status == ST_INCOMPLETE && !out_data.parsing)
  // a closing delimiter belongs to a field
  `HRSP_ASSERT_IMP(a_end_tag, out_valid && out_data.field_end,
                   out_data.field_tag != TAG_NONE && !out_data.out_valid)

endmodule

bind http_request_stream_parser_top hrsp_checker u_hrsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/http_request_stream_parser_top_test.sv
// ----------------------------------------------------------------------------
// http_request_stream_parser_top_test
// self-checking bench for the byte-serial request parser
// ----------------------------------------------------------------------------
// Feeds requests byte by byte (well-formed requests with random content,
// broken requests and raw noise) with random gaps and back-pressure. A
// behavioral copy of the parser predicts every result word, and a small
// scoreboard compares each one, field by field, in order.
`timescale 1ns / 1ps

module http_request_stream_parser_top_test;
  import hrsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // parser phases, local to the predictor
  localparam logic [3:0] P_IDLE = 4'd0, P_METHOD = 4'd1, P_PATH = 4'd2, P_QNAME = 4'd3;
  localparam logic [3:0] P_QVALUE = 4'd4, P_VERSION = 4'd5, P_HNAME = 4'd6;
  localparam logic [3:0] P_HVALUE = 4'd7, P_BLANK = 4'd8, P_BODY = 4'd9;
  localparam logic KIND_BYTE = 1'b0, KIND_CLEAR = 1'b1;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  class parse_scoreboard;
    out_word_t pending[$];
    int errors;
    int checked;
    int complete_seen;
    int status_seen[8];
    logic [3:0] phase, mpos;
    logic [7:0] mcand;
    logic [2:0] vcand;
    logic [1:0] hncand, hvcand, esc, nph;
    logic [3:0] hi;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W:0] bcnt;
    logic ka, started;
    logic [2:0] stat;

    function void clear_state();
      phase = P_IDLE; mpos = 0; mcand = 8'hff; vcand = 3'h7; hncand = 2'h3;
      hvcand = 2'h3; esc = 0; hi = 0; dlen = 0; nph = 0; bcnt = 0; ka = 0;
      stat = ST_INCOMPLETE; started = 0;
    endfunction

    function void fail_with(logic [2:0] code);
      if (stat == ST_INCOMPLETE || stat == ST_COMPLETE) stat = code;
    endfunction

    function void close_to(logic [3:0] nxt);
      if (esc != 0) fail_with(ST_BAD_ESCAPE);
      esc = 0; hi = 0; mpos = 0; started = 0; phase = nxt;
    endfunction

    function logic hit(logic [127:0] s, logic [3:0] len, logic [7:0] b);
      logic [3:0] k;
      k = len - 4'd1 - mpos;
      return (mpos < len) && (s[k*8 +: 8] == b);
    endfunction

    function void bump();
      if (mpos < 4'd15) mpos++;
    endfunction

    function int hexv(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void number_char(logic [7:0] b);
      logic dig;
      logic [LEN_W-1:0] d;
      dig = (b >= "0" && b <= "9");
      d = LEN_W'(b - "0");
      if (nph == 0) begin
        if (b == " " || b == "\t") return;
        if (!dig) begin nph = 3; return; end
        nph = 1;
      end else if (nph == 1) begin
        if (!dig) begin nph = 2; return; end
      end else return;
      if (dlen > (LEN_SAT - d) / 10) dlen = LEN_SAT;
      else dlen = dlen * 10 + d;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      logic [7:0] b;
      logic [7:0] m;
      int h;
      r = '0;
      b = w.data_byte;
      if (w.kind == KIND_CLEAR) clear_state();
      else if (stat == ST_INCOMPLETE || stat == ST_COMPLETE) begin
        if (phase == P_IDLE) phase = P_METHOD;
        case (phase)
          P_METHOD: begin
            r.field_tag = TAG_METHOD;
            if (b == " ") begin
              r.field_end = 1;
              m = mcand;
              for (int i = 0; i < 8; i++) if (METH_LEN[i] != mpos) m[i] = 0;
              if (m[1:0] == 0) fail_with(m != 0 ? ST_BAD_METHOD : ST_BAD_REQUEST);
              close_to(P_PATH);
            end else begin
              for (int i = 0; i < 8; i++) if (!hit(METH_TXT[i], METH_LEN[i], b)) mcand[i] = 0;
              bump();
              started = 1; r.out_valid = 1; r.out_byte = b;
            end
          end
          P_PATH, P_QNAME, P_QVALUE: begin
            r.field_tag = phase;
            if (b == " ") begin
              r.field_end = 1; close_to(P_VERSION);
            end else if (phase == P_PATH && b == "?") begin
              r.field_end = 1; close_to(P_QNAME);
            end else if (phase == P_QNAME && b == "=") begin
              r.field_end = 1; close_to(P_QVALUE);
            end else if (phase == P_QVALUE && b == "&") begin
              r.field_end = 1; close_to(P_QNAME);
            end else begin
              started = 1;
              if (esc == 0) begin
                if (b == "%") esc = 1;
                else begin r.out_valid = 1; r.out_byte = (b == "+") ? 8'h20 : b; end
              end else begin
                h = hexv(b);
                if (h < 0) begin fail_with(ST_BAD_ESCAPE); esc = 0; end
                else if (esc == 1) begin hi = h[3:0]; esc = 2; end
                else begin r.out_valid = 1; r.out_byte = {hi, h[3:0]}; esc = 0; end
              end
            end
          end
          P_VERSION: begin
            r.field_tag = TAG_VERSION;
            if (b == "\n") begin
              r.field_end = 1;
              m = {5'd0, vcand};
              for (int i = 0; i < 3; i++) if (VER_LEN[i] != mpos) m[i] = 0;
              if (m[1:0] == 0) fail_with(m[2] ? ST_BAD_VERSION : ST_BAD_REQUEST);
              close_to(P_HNAME);
              hncand = 3;
            end else if (b != "\r") begin
              for (int i = 0; i < 3; i++) if (!hit(VER_TXT[i], VER_LEN[i], b)) vcand[i] = 0;
              bump();
              started = 1; r.out_valid = 1; r.out_byte = b;
            end
          end
          P_HNAME: begin
            if (!started && b == "\r") phase = P_BLANK;
            else begin
              r.field_tag = TAG_HNAME;
              started = 1;
              if (b == " ") begin
                r.field_end = 1;
                for (int i = 0; i < 2; i++) if (HN_LEN[i] != mpos) hncand[i] = 0;
                hvcand = 3;
                if (hncand[0]) begin dlen = 0; nph = 0; end
                close_to(P_HVALUE);
              end else if (b != ":") begin
                for (int i = 0; i < 2; i++) if (!hit(HN_TXT[i], HN_LEN[i], b)) hncand[i] = 0;
                bump();
                r.out_valid = 1; r.out_byte = b;
              end
            end
          end
          P_HVALUE: begin
            r.field_tag = TAG_HVALUE;
            if (b == "\n") begin
              r.field_end = 1;
              if (hncand[0]) begin
                if (nph == 0 || nph == 3) fail_with(ST_BAD_REQUEST);
              end else if (hncand[1]) begin
                m = {6'd0, hvcand};
                for (int i = 0; i < 2; i++) if (HV_LEN[i] != mpos) m[i] = 0;
                if (m[0]) ka = 1;
                else if (m[1]) ka = 0;
                else fail_with(ST_BAD_REQUEST);
              end
              close_to(P_HNAME);
              hncand = 3;
            end else if (b != "\r") begin
              for (int i = 0; i < 2; i++) if (!hit(HV_TXT[i], HV_LEN[i], b)) hvcand[i] = 0;
              bump();
              if (hncand[0]) number_char(b);
              started = 1; r.out_valid = 1; r.out_byte = b;
            end
          end
          P_BLANK: begin
            if (b == "\n") begin
              phase = P_BODY;
              if (dlen == 0) stat = ST_COMPLETE;
            end else fail_with(ST_BAD_REQUEST);
          end
          P_BODY: begin
            r.field_tag = TAG_BODY;
            if (dlen == 0) fail_with(ST_BAD_REQUEST);
            else if (bcnt < {1'b0, dlen}) begin
              bcnt++;
              r.out_valid = 1; r.out_byte = b;
              if (bcnt == {1'b0, dlen}) stat = ST_COMPLETE;
            end else begin
              bcnt = {1'b0, dlen} + 1;
              fail_with(ST_OVERFLOW);
            end
          end
          default: fail_with(ST_BAD_REQUEST);
        endcase
      end
      r.status = stat;
      r.keep_alive = ka;
      r.parsing = (phase != P_IDLE && stat != ST_COMPLETE);
      r.content_length = dlen;
      pending = {pending, r};
      status_seen[stat]++;
      if (stat == ST_COMPLETE) complete_seen++;
    endfunction

    function void check_word(out_word_t act);
      out_word_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, act);
        return;
      end
      e = pending.pop_front();
      if (act.field_tag !== e.field_tag || act.out_byte !== e.out_byte ||
          act.out_valid !== e.out_valid || act.field_end !== e.field_end ||
          act.status !== e.status || act.keep_alive !== e.keep_alive ||
          act.parsing !== e.parsing || act.content_length !== e.content_length) begin
        errors++;
        $display("%0t: mismatch exp tag=%0d byte=%h v=%b end=%b st=%0d ka=%b p=%b len=%0d",
                 $time, e.field_tag, e.out_byte, e.out_valid, e.field_end, e.status,
                 e.keep_alive, e.parsing, e.content_length);
        $display("%0t:          act tag=%0d byte=%h v=%b end=%b st=%0d ka=%b p=%b len=%0d",
                 $time, act.field_tag, act.out_byte, act.out_valid, act.field_end, act.status,
                 act.keep_alive, act.parsing, act.content_length);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;

  parse_scoreboard sb;
  byte unsigned txt[$];
  int sent;
  bit idle_on;
  bit hold_rx;
  bit stim_done;
  int quiet;

  http_request_stream_parser_top u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // called at a falling edge; valid stays up for a following word
  task automatic send_word(logic k, logic [7:0] b);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{kind: k, data_byte: b};
    @(posedge clk);
    while (!(in_ready === 1'b1)) @(posedge clk);
    sb.note_word('{kind: k, data_byte: b});
    sent++;
    @(negedge clk);
  endtask

  // sends pending text, then drops it
  task automatic flush_text();
    while (txt.size() > 0) send_word(KIND_BYTE, txt.pop_front());
  endtask

  function automatic void append_byte(byte unsigned c);
    txt = {txt, c};
  endfunction

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic string rand_token(int n);
    string s;
    byte unsigned c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = "a" + $urandom_range(25);
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic void build_request();
    string meths[8] = '{"GET", "POST", "PUT", "HEAD", "DELETE", "BREW", "OPTIONS", "GE"};
    string vers[4] = '{"HTTP/1.1", "HTTP/1.0", "HTTP/2.0", "HTTP/1.2"};
    int blen;
    int r;
    r = $urandom_range(99);
    put(r < 80 ? meths[$urandom_range(1)] : meths[$urandom_range(7)]);
    put(" /");
    put(rand_token($urandom_range(4)));
    if ($urandom_range(3) == 0) put("%2f");
    if ($urandom_range(5) == 0) put("%g");
    if ($urandom_range(2) == 0) begin
      put("?"); put(rand_token($urandom_range(1, 3))); put("=");
      put(rand_token($urandom_range(3))); put("+");
      if ($urandom_range(1)) begin put("&"); put(rand_token(2)); put("=%4A"); end
    end
    put(" ");
    put($urandom_range(9) < 8 ? vers[$urandom_range(1)] : vers[$urandom_range(3)]);
    put("\r\n");
    blen = $urandom_range(5);
    if ($urandom_range(9) < 8) put($sformatf("Content-Length:  %0d\r\n", blen));
    else blen = 0;
    case ($urandom_range(3))
      0: put("Connection: keep-alive\r\n");
      1: put("Connection: close\r\n");
      2: put("Connection: maybe\r\n");
      default: put("X-Tag: zz\r\n");
    endcase
    put("\r\n");
    for (int i = 0; i < blen; i++) append_byte(8'($urandom_range(255)));
    if ($urandom_range(7) == 0) append_byte(8'($urandom_range(255)));
    // occasionally break the sequence
    if ($urandom_range(9) == 0) txt[$urandom_range(txt.size() - 1)] = $urandom_range(255);
  endfunction

  // receiver
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) out_ready <= 0;
      else out_ready <= !(idle_on && $urandom_range(99) < 36);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) sb.check_word(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else if (!stim_done || sb.pending.size() > 0) begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 0; in_valid = 0; in_data = '0; idle_on = 0; hold_rx = 0; stim_done = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: full request with overflowing length and body extremes
    put("GET /a%4Fb+?x=1&y=%zz HTTP/1.1\r\nContent-Length: 99999999999\r\n");
    put("Connection: keep-alive\r\n\r\n");
    append_byte(8'h00); append_byte(8'hff);
    flush_text();
    send_word(KIND_CLEAR, 8'hff);
    put("OPTIONS * HTTP/2.0\n\r\n");
    flush_text();
    send_word(KIND_CLEAR, 8'h00);

    // pressure: receiver holds off while the sender keeps going
    hold_rx = 1;
    fork
      begin repeat (60) @(posedge clk); hold_rx = 0; end
      begin
        put("POST /q HTTP/1.0\r\nContent-Length: 1\r\n\r\nZZ");
        flush_text();
        in_valid <= 0;
      end
    join
    @(negedge clk);

    idle_on = 1;
    while (sent < 815) begin
      if (sent > 500 && sent < 650) idle_on = 0;
      else idle_on = 1;
      send_word(KIND_CLEAR, $urandom_range(255));
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 20)) append_byte(8'($urandom_range(255)));
      end else build_request();
      flush_text();
    end
    in_valid <= 0;
    stim_done = 1;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d words, %0d results checked, %0d complete-status results",
             sent, sb.checked, sb.complete_seen);
    $display("status hits: bad method %0d, bad version %0d, bad request %0d, escape %0d, ovf %0d",
             sb.status_seen[2], sb.status_seen[3], sb.status_seen[4], sb.status_seen[5],
             sb.status_seen[6]);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
